### src/segment_lcd_serial_writer_assert.svh
// Assertion macros for the segment LCD serial writer.
`ifndef SEGMENT_LCD_SERIAL_WRITER_ASSERT_SVH
`define SEGMENT_LCD_SERIAL_WRITER_ASSERT_SVH

// Same-cycle implication, checked on every clock outside reset.
`define SLCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slcd assertion failed");

// Next-cycle implication, checked on every clock outside reset.
`define SLCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slcd assertion failed");

`endif

### src/slcd_pkg.sv
// Shared types and constants for the segment LCD serial writer.
package slcd_pkg;

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_ADDR  = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;
  localparam logic [1:0] CMD_END   = 2'd3;

  localparam logic [2:0] ID_CMD    = 3'b100;
  localparam logic [2:0] ID_DATA   = 3'b101;

  localparam logic       KIND_BIT     = 1'b0;
  localparam logic       KIND_RELEASE = 1'b1;

  localparam int         WORD_W    = 12;
  localparam logic [3:0] CNT_HDR_CMD = 4'd12;
  localparam logic [3:0] CNT_CMD     = 4'd9;
  localparam logic [3:0] CNT_ADDR    = 4'd9;
  localparam logic [3:0] CNT_DATA    = 4'd8;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_CMD  = 2'd1,
    MODE_DATA = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic event_kind;
    logic bit_value;
    logic last_of_run;
  } evt_t;

  typedef struct packed {
    logic              rel;
    logic [3:0]        count;
    logic [WORD_W-1:0] word;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### src/slcd_front.sv
// Front end: tracks the open frame and turns each request that yields beats into a job.
module slcd_front import slcd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  req_t    req,
  input  q_stat_t q_stat,
  output logic    push,
  output job_t    job
);

  mode_t mode;
  mode_t mode_next;
  logic  take;

  assign req_stall = q_stat.full;
  assign take      = req_valid && !q_stat.full;
  assign push      = take && (job.rel || (job.count != 4'd0));

  always_comb begin
    mode_next = mode;
    case (req.cmd)
      CMD_BYTE: mode_next = MODE_CMD;
      CMD_ADDR: mode_next = MODE_DATA;
      CMD_DATA: begin
        if (mode != MODE_DATA) mode_next = MODE_NONE;
      end
      default:  mode_next = MODE_NONE;
    endcase
  end

  always_comb begin
    job = '0;
    case (req.cmd)
      CMD_BYTE: begin
        if (mode != MODE_CMD) begin
          job.rel   = (mode != MODE_NONE);
          job.word  = {ID_CMD, req.value, 1'b0};
          job.count = CNT_HDR_CMD;
        end else begin
          job.word  = {req.value, 1'b0, 3'b000};
          job.count = CNT_CMD;
        end
      end
      CMD_ADDR: begin
        job.rel   = (mode != MODE_NONE);
        job.word  = {ID_DATA, req.value[5:0], 3'b000};
        job.count = CNT_ADDR;
      end
      CMD_DATA: begin
        if (mode == MODE_DATA) begin
          job.word  = {req.value, 4'b0000};
          job.count = CNT_DATA;
        end else begin
          job.rel = (mode != MODE_NONE);
        end
      end
      default: job.rel = (mode != MODE_NONE);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NONE;
    end else if (take) begin
      mode <= mode_next;
    end
  end

endmodule

### src/slcd_queue.sv
// Two-entry job queue between front and back.
module slcd_queue import slcd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign stat.full  = (fill == 2'd2);
  assign stat.empty = (fill == 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### src/slcd_back.sv
// Back end: shifts one job out as strobed bits and releases, one beat a cycle while evt_stall does not hold it.
module slcd_back import slcd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  job_t    head,
  input  q_stat_t q_stat,
  output logic    pop,
  output logic    busy,
  output logic    evt_valid,
  input  logic    evt_stall,
  output evt_t    evt
);

  logic              rel;
  logic [3:0]        cnt;
  logic [WORD_W-1:0] word;
  logic              adv;
  logic              last;

  assign adv  = busy && (!evt_valid || !evt_stall);
  assign last = rel ? (cnt == 4'd0) : (cnt == 4'd1);
  assign pop  = !q_stat.empty && (!busy || (adv && last));

  always_ff @(posedge clk) begin
    if (adv) begin
      evt.last_of_run <= last;
      if (rel) begin
        evt.event_kind <= KIND_RELEASE;
        evt.bit_value  <= 1'b0;
      end else begin
        evt.event_kind <= KIND_BIT;
        evt.bit_value  <= word[WORD_W-1];
      end
    end
    if (pop) begin
      rel  <= head.rel;
      cnt  <= head.count;
      word <= head.word;
    end else if (adv) begin
      if (rel) begin
        rel <= 1'b0;
      end else begin
        word <= {word[WORD_W-2:0], 1'b0};
        cnt  <= cnt - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      evt_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (adv && last) begin
        busy <= 1'b0;
      end
      if (adv) begin
        evt_valid <= 1'b1;
      end else if (!evt_stall) begin
        evt_valid <= 1'b0;
      end
    end
  end

endmodule

### src/segment_lcd_serial_writer.sv
// Top level of the segment LCD serial writer: front end, job queue, back end.
//
// Each accepted request becomes zero to thirteen result beats (an optional
// chip-select release, then ID, address/command/data and pad bits). The back
// end's shift register sends one beat per cycle while the output does not
// stall, and consecutive jobs follow without a gap; requests that produce
// nothing push no job. A two-entry job queue decouples request intake from
// serialization: the request channel stalls only while that queue is full.
`include "segment_lcd_serial_writer_assert.svh"

module segment_lcd_serial_writer import slcd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic evt_valid,
  input  logic evt_stall,
  output evt_t evt
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  logic    busy;
  job_t    push_job;
  job_t    head;

  slcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_stat    (q_stat),
    .push      (push),
    .job       (push_job)
  );

  slcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  slcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .busy      (busy),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

  `SLCD_ASSERT_NOW(a_q_full_not_empty, q_stat.full, !q_stat.empty)
  `SLCD_ASSERT_NOW(a_release_low, evt_valid && evt.event_kind, !evt.bit_value)
  `SLCD_ASSERT_NEXT(a_push_fills, push && !pop, !q_stat.empty)
  `SLCD_ASSERT_NEXT(a_pop_starts, pop, busy)

endmodule
